@@ hw/rtl/tts_pkg.sv @@
package tts_pkg;

  localparam int SAMPLE_RATE     = 48000;
  localparam int TONE_LENGTH_MS  = 550;
  localparam int SINE_TABLE_BITS = 10;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);

  localparam logic [16:0] ENV_ONE  = 17'd65536;
  localparam logic [16:0] ENV_UP   = 17'(65536 / (SAMPLE_RATE * 20 / 1000));
  localparam logic [16:0] ENV_DOWN = 17'(65536 / (SAMPLE_RATE * 40 / 1000));

  localparam logic [16:0] GAIN_RESET = 17'd65536;
  localparam logic [31:0] HIGH_RESET =
    32'(((64'd880 << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
  localparam logic [31:0] LOW_RESET =
    32'(((64'd660 << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
  localparam logic [19:0] TONE_RESET = 20'((SAMPLE_RATE / 1000) * TONE_LENGTH_MS);

  localparam logic [8:0]  GLIDE_MUL = 9'd262;
  localparam logic [14:0] MIX_SCALE = 15'd24960;
  localparam logic [6:0]  DIV_K     = 7'd105;
  // floor(2^31 / 105), quotient estimate low by at most one
  localparam logic [24:0] DIV_RECIP = 25'((64'd1 << 31) / 64'd105);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes
  localparam logic [7:0] REG_GAIN      = 8'd0;
  localparam logic [7:0] REG_HIGH_STEP = 8'd1;
  localparam logic [7:0] REG_LOW_STEP  = 8'd2;
  localparam logic [7:0] REG_TONE_SAMP = 8'd3;

  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef logic [15:0] qtab_t [QUARTER+1];

  // sin(i * (pi/2) / QUARTER) * 32767, rounded, integer Taylor series
  function automatic logic [15:0] quarter_sine(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (HALF_PI_Q30 * 64'(i)) >> (SINE_TABLE_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    sum  = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (sum > 64'd32767) return 16'd32767;
    return sum[15:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= QUARTER; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

@@ hw/rtl/two_tone_siren_synth.sv @@
// Two-tone siren synthesizer. Each accepted request is one sample tick and
// yields exactly one sample. Every glide, harmonic phase, harmonic weight,
// envelope, gain and divide-by-105 product runs through one shared signed
// 41x26 multiplier with a registered product, stepped by a 14-state
// sequencer: glide, step update and envelope, then the four harmonics, then
// the magnitude, envelope, gain and reciprocal-divide chain. in_stall_o is
// high while a request is at work, so a new request is taken only once the
// sequencer is back in idle. The finished sample sits in an output register
// so the next request may be taken while it waits. A result stalled
// at the output holds the sequencer in its last step. Configuration writes
// are taken every cycle (cfg_ready_o is always high) and should only be made
// while the block is idle; index 0 gain, 1 high_step, 2 low_step,
// 3 tone_samples, any other index is ignored. The sine table is a quarter
// wave built at elaboration and read with a registered output.
module two_tone_siren_synth (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               start_req_i,
  input  logic               stop_i,
  input  logic               block_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               done_res_o,
  output logic               block_end_out_o
);
  import tts_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GLIDE = 4'd1;
  localparam logic [3:0] ST_STEP  = 4'd2;
  localparam logic [3:0] ST_ENV   = 4'd3;
  localparam logic [3:0] ST_HMUL  = 4'd4;
  localparam logic [3:0] ST_HADR  = 4'd5;
  localparam logic [3:0] ST_HWGT  = 4'd6;
  localparam logic [3:0] ST_HSUM  = 4'd7;
  localparam logic [3:0] ST_MAG   = 4'd8;
  localparam logic [3:0] ST_ENVM  = 4'd9;
  localparam logic [3:0] ST_GAIN  = 4'd10;
  localparam logic [3:0] ST_RECIP = 4'd11;
  localparam logic [3:0] ST_QMUL  = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;

  // configuration
  logic [16:0] gain_q;
  logic [31:0] high_q, lowst_q;
  logic [19:0] tsamp_q;

  // synth state
  logic [3:0]         state_q, state_d;
  logic [31:0]        phase_q, phase_d;
  logic [31:0]        cur_q, cur_d;
  logic [16:0]        env_q, env_d;
  logic [19:0]        cnt_q, cnt_d;
  logic               low_q, low_d;
  logic               stop_q, stop_d;
  logic               done_q, done_d;
  logic               up_q, up_d;
  logic               bend_q, bend_d;
  logic               neg_q, neg_d;
  logic [1:0]         hidx_q, hidx_d;
  logic signed [23:0] acc_q, acc_d;
  logic [23:0]        x_q, x_d;
  logic [16:0]        q0_q, q0_d;

  // output register
  logic               ovld_q, ovld_d;
  logic signed [15:0] osmp_q, osmp_d;
  logic               odone_q, odone_d;
  logic               obend_q, obend_d;

  mul_req_t                  mreq;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [15:0]        rom_data;

  logic        accept;
  logic [31:0] target, diff, dstep;
  logic [19:0] cnt_inc;
  logic [23:0] acc_abs, rem;
  logic [16:0] gclip;
  logic [17:0] mval;

  tts_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  tts_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (prod[31 -: SINE_TABLE_BITS]),
    .data_o (rom_data)
  );

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != ST_IDLE);
  assign accept          = in_valid_i && !in_stall_o;
  assign out_valid_o     = ovld_q;
  assign sample_o        = osmp_q;
  assign done_res_o      = odone_q;
  assign block_end_out_o = obend_q;

  assign target  = low_q ? lowst_q : high_q;
  assign diff    = (target >= cur_q) ? (target - cur_q) : (cur_q - target);
  assign dstep   = prod[47:16];
  assign cnt_inc = cnt_q + 20'd1;
  assign acc_abs = acc_q[23] ? 24'(-acc_q) : 24'(acc_q);
  assign gclip   = (gain_q > ENV_ONE) ? ENV_ONE : gain_q;
  assign rem     = x_q - prod[23:0];
  assign mval    = {1'b0, q0_q} + ((rem >= 24'(DIV_K)) ? 18'd1 : 18'd0);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cur_d   = cur_q;
    env_d   = env_q;
    cnt_d   = cnt_q;
    low_d   = low_q;
    stop_d  = stop_q;
    done_d  = done_q;
    up_d    = up_q;
    bend_d  = bend_q;
    neg_d   = neg_q;
    hidx_d  = hidx_q;
    acc_d   = acc_q;
    x_d     = x_q;
    q0_d    = q0_q;
    ovld_d  = ovld_q && out_stall_i;
    osmp_d  = osmp_q;
    odone_d = odone_q;
    obend_d = obend_q;
    mreq    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // restart comes first, then stop latches
          if (start_req_i) begin
            phase_d = '0;
            cur_d   = high_q;
            env_d   = '0;
            cnt_d   = '0;
            low_d   = 1'b0;
            done_d  = 1'b0;
          end
          stop_d  = stop_i || (stop_q && !start_req_i);
          bend_d  = block_end_i;
          state_d = ST_GLIDE;
        end
      end
      ST_GLIDE: begin
        mreq.a  = {9'd0, diff};
        mreq.b  = {17'd0, GLIDE_MUL};
        up_d    = (target >= cur_q);
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cur_d   = up_q ? (cur_q + dstep) : (cur_q - dstep);
        state_d = ST_ENV;
      end
      ST_ENV: begin
        phase_d = phase_q + cur_q;
        if (stop_q) begin
          if (env_q <= ENV_DOWN) begin
            env_d  = '0;
            done_d = 1'b1;
          end else begin
            env_d = env_q - ENV_DOWN;
          end
        end else if (env_q < ENV_ONE) begin
          env_d = ((env_q + ENV_UP) > ENV_ONE) ? ENV_ONE : (env_q + ENV_UP);
        end
        if (cnt_inc >= tsamp_q) begin
          cnt_d = '0;
          low_d = !low_q;
        end else begin
          cnt_d = cnt_inc;
        end
        acc_d   = '0;
        hidx_d  = '0;
        state_d = ST_HMUL;
      end
      ST_HMUL: begin
        // harmonic order 2h+1
        mreq.a  = {9'd0, phase_q};
        mreq.b  = {23'd0, hidx_q, 1'b1};
        state_d = ST_HADR;
      end
      ST_HADR: begin
        state_d = ST_HWGT;
      end
      ST_HWGT: begin
        mreq.a = {{(MUL_A_W-16){rom_data[15]}}, rom_data};
        unique case (hidx_q)
          2'd0:    mreq.b = 26'sd105;
          2'd1:    mreq.b = 26'sd35;
          2'd2:    mreq.b = 26'sd21;
          default: mreq.b = 26'sd15;
        endcase
        state_d = ST_HSUM;
      end
      ST_HSUM: begin
        acc_d = acc_q + $signed(prod[23:0]);
        if (hidx_q == 2'd3) begin
          state_d = ST_MAG;
        end else begin
          hidx_d  = hidx_q + 2'd1;
          state_d = ST_HMUL;
        end
      end
      ST_MAG: begin
        neg_d   = acc_q[23];
        mreq.a  = {17'd0, acc_abs};
        mreq.b  = {11'd0, MIX_SCALE};
        state_d = ST_ENVM;
      end
      ST_ENVM: begin
        mreq.a  = {3'd0, prod[37:0]};
        mreq.b  = {9'd0, env_q};
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        mreq.a  = {3'd0, prod[53:16]};
        mreq.b  = {9'd0, gclip};
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        x_d     = prod[54:31];
        mreq.a  = {17'd0, prod[54:31]};
        mreq.b  = {1'b0, DIV_RECIP};
        state_d = ST_QMUL;
      end
      ST_QMUL: begin
        q0_d    = prod[47:31];
        mreq.a  = {24'd0, prod[47:31]};
        mreq.b  = {19'd0, DIV_K};
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold product inputs so rem stays valid while waiting
        mreq.a = {24'd0, q0_q};
        mreq.b = {19'd0, DIV_K};
        if (!(ovld_q && out_stall_i)) begin
          ovld_d = 1'b1;
          if (neg_q) begin
            osmp_d = (mval >= 18'd32768) ? -16'sd32768 : -$signed(mval[15:0]);
          end else begin
            osmp_d = (mval >= 18'd32767) ? 16'sd32767 : $signed(mval[15:0]);
          end
          odone_d = done_q;
          obend_d = bend_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      high_q  <= HIGH_RESET;
      lowst_q <= LOW_RESET;
      tsamp_q <= TONE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GAIN:      gain_q  <= cfg_data_i[16:0];
        REG_HIGH_STEP: high_q  <= cfg_data_i;
        REG_LOW_STEP:  lowst_q <= cfg_data_i;
        REG_TONE_SAMP: tsamp_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      cur_q   <= HIGH_RESET;
      env_q   <= '0;
      cnt_q   <= '0;
      low_q   <= 1'b0;
      stop_q  <= 1'b0;
      done_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cur_q   <= cur_d;
      env_q   <= env_d;
      cnt_q   <= cnt_d;
      low_q   <= low_d;
      stop_q  <= stop_d;
      done_q  <= done_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q    <= up_d;
    bend_q  <= bend_d;
    neg_q   <= neg_d;
    hidx_q  <= hidx_d;
    acc_q   <= acc_d;
    x_q     <= x_d;
    q0_q    <= q0_d;
    osmp_q  <= osmp_d;
    odone_q <= odone_d;
    obend_q <= obend_d;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted but sequencer not busy");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (env_q == '0))
    else $error("done set with nonzero envelope");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= ENV_ONE)
    else $error("envelope above unity");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && ovld_q && out_stall_i |=> (state_q == ST_FIN))
    else $error("result dropped while output stalled");
`endif

endmodule

@@ hw/rtl/tts_sine_rom.sv @@
module tts_sine_rom (
  input  logic                                 clk_i,
  input  logic [tts_pkg::SINE_TABLE_BITS-1:0]  addr_i,
  output logic signed [15:0]                   data_o
);
  import tts_pkg::*;

  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-3:0]   off;
  logic [SINE_TABLE_BITS-2:0]   idx;
  logic [15:0]                  mag;

  assign quad = addr_i[SINE_TABLE_BITS-1 -: 2];
  assign off  = addr_i[SINE_TABLE_BITS-3:0];
  // mirror in odd quadrants, negate in the second half
  assign idx  = quad[0] ? ((SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, off}) : {1'b0, off};
  assign mag  = QTAB[idx];

  always_ff @(posedge clk_i) begin
    data_o <= quad[1] ? -$signed(mag) : $signed(mag);
  end

endmodule

@@ hw/rtl/tts_mul.sv @@
module tts_mul (
  input  logic                                   clk_i,
  input  tts_pkg::mul_req_t                      req_i,
  output logic signed [tts_pkg::MUL_P_W-1:0]     prod_o
);
  import tts_pkg::*;

  always_ff @(posedge clk_i) begin
    prod_o <= MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
  end

endmodule

@@ verif/tb_two_tone_siren_synth.sv @@
`timescale 1ns / 100ps

module tb_two_tone_siren_synth;
  import tts_pkg::*;

  localparam int TBL       = 1 << SINE_TABLE_BITS;
  localparam int LAT       = 40;
  localparam int MAX_CYCLE = 3000000;

  typedef struct {
    logic signed [15:0] sample;
    logic               done;
    logic               blk_end;
  } siren_out_t;

  // Scoreboard: carries its own copy of the siren state and registers and
  // queues one expected sample per accepted request.
  class siren_scoreboard;
    int          sine_tab [TBL];
    logic [16:0] gain_r;
    logic [31:0] hi_step_r, lo_step_r;
    logic [19:0] tone_len_r;
    logic [31:0] phase, step;
    logic [16:0] env;
    logic [19:0] tone_cnt;
    bit          low_tone, fading, silent;
    siren_out_t  exp_q [$];
    int          n_err, n_ok, n_done;

    function new();
      longint unsigned x, x2, term, acc;
      int q, v;
      q = TBL / 4;
      for (int i = 0; i <= q; i++) begin
        x    = HALF_PI_Q30 * longint'(i) / longint'(q);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 6; k++) begin
          term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        acc = (acc * 32767 + (64'd1 << 29)) >> 30;
        v = (acc > 32767) ? 32767 : int'(acc);
        sine_tab[i] = v;
        sine_tab[(2 * q - i) % TBL] = v;
        if (i != 0) sine_tab[(2 * q + i) % TBL] = -v;
        if (i != q) sine_tab[(4 * q - i) % TBL] = -v;
      end
      sine_tab[0] = 0;
      sine_tab[2 * q] = 0;
      gain_r     = GAIN_RESET;
      hi_step_r  = HIGH_RESET;
      lo_step_r  = LOW_RESET;
      tone_len_r = TONE_RESET;
      restart();
    endfunction

    function void restart();
      phase    = '0;
      step     = hi_step_r;
      env      = '0;
      tone_cnt = '0;
      low_tone = 0;
      fading   = 0;
      silent   = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_GAIN:      gain_r     = data[16:0];
        REG_HIGH_STEP: hi_step_r  = data;
        REG_LOW_STEP:  lo_step_r  = data;
        REG_TONE_SAMP: tone_len_r = data[19:0];
        default: ;
      endcase
    endfunction

    function longint harm(int k);
      logic [31:0] p;
      p = phase * 32'(k);
      return longint'(sine_tab[p >> (32 - SINE_TABLE_BITS)]);
    endfunction

    // one sample tick
    function void note_request(bit st, bit sp, bit be);
      logic [31:0] tgt;
      longint unsigned d, m, g;
      longint s;
      int mag, q;
      siren_out_t e;
      if (st) restart();
      if (sp) fading = 1;
      tgt = low_tone ? lo_step_r : hi_step_r;
      if (tgt >= step) begin
        d = (longint'(tgt - step) * 262) >> 16;
        step = step + 32'(d);
      end else begin
        d = (longint'(step - tgt) * 262) >> 16;
        step = step - 32'(d);
      end
      phase = phase + step;
      if (fading) begin
        if (env <= ENV_DOWN) begin
          env    = '0;
          silent = 1;
        end else env = env - ENV_DOWN;
      end else if (env < ENV_ONE) begin
        env = env + ENV_UP;
        if (env > ENV_ONE) env = ENV_ONE;
      end
      s = 105 * harm(1) + 35 * harm(3) + 21 * harm(5) + 15 * harm(7);
      m = (s < 0) ? -s : s;
      m = (m * 24960 * longint'(env)) >> 16;
      g = (gain_r > 17'd65536) ? 65536 : longint'(gain_r);
      m = (m * g) / (64'd105 << 31);
      mag = (m > 65536) ? 65536 : int'(m);
      q = (s < 0) ? -mag : mag;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      tone_cnt = tone_cnt + 20'd1;
      if (tone_cnt >= tone_len_r) begin
        tone_cnt = '0;
        low_tone = !low_tone;
      end
      e.sample  = 16'(q);
      e.done    = silent;
      e.blk_end = be;
      exp_q.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] smp, logic dn, logic be);
      siren_out_t e;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected sample %0d", $time, smp);
        n_err++;
        return;
      end
      e = exp_q.pop_front();
      if (smp !== e.sample) begin
        $display("%0t: sample exp %0d got %0d", $time, e.sample, smp);
        n_err++;
      end
      if (dn !== e.done) begin
        $display("%0t: done_res exp %0b got %0b", $time, e.done, dn);
        n_err++;
      end
      if (be !== e.blk_end) begin
        $display("%0t: block_end_out exp %0b got %0b", $time, e.blk_end, be);
        n_err++;
      end
      if (dn === 1'b1) n_done++;
      n_ok++;
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        start_req_i = 1'b0;
  logic        stop_i      = 1'b0;
  logic        block_end_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        cfg_ready_o, in_stall_o, out_valid_o, done_res_o, block_end_out_o;
  logic signed [15:0] sample_o;

  siren_scoreboard sb = new();
  bit  no_idle;      // phases that run back to back, no gaps or stalls
  int  n_cfg;
  int  cycles;

  two_tone_siren_synth u_top (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output side: random stall, check each accepted sample
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(sample_o, done_res_o, block_end_out_o);
      out_stall_i <= (idle_len() != 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
    n_cfg++;
    @(posedge clk_i);
  endtask

  // one sample request; valid stays high when the next one follows at once
  task automatic send_tick(bit st, bit sp, bit be);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= st;
    stop_i      <= sp;
    block_end_i <= be;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(st, sp, be);
  endtask

  // drain before touching registers; every request yields a sample
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  // random ticks: rare restart, rarer stop, frequent block marks
  task automatic random_ticks(int n);
    for (int i = 0; i < n; i++)
      send_tick($urandom_range(0, 99) < 2, $urandom_range(0, 199) < 1,
                $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every flag combination, start together with stop
    for (int i = 0; i < 8; i++) send_tick(i[0], i[1], i[2]);
    send_tick(1, 1, 1);
    send_tick(1, 0, 0);
    random_ticks(10);

    // full rise up to the unity clamp, held a while
    no_idle = 1;
    send_tick(1, 0, 0);
    for (int i = 0; i < 980; i++) send_tick(0, 0, i[0]);
    no_idle = 0;

    // short rise, then a fade all the way to silence and a few ticks after
    send_tick(1, 0, 0);
    for (int i = 0; i < 25; i++) send_tick(0, 0, i[2]);
    send_tick(0, 1, 0);
    no_idle = 1;
    for (int i = 0; i < 60; i++) send_tick(0, 0, i[3]);
    no_idle = 0;
    send_tick(0, 0, 1);
    send_tick(0, 1, 1);
    send_tick(1, 0, 0);   // restart clears done
    settle();

    // register extremes: gain above one, max high step, zero low step, zero tone length
    write_cfg(REG_GAIN, 32'hFFFF_FFFF);
    write_cfg(REG_HIGH_STEP, 32'hFFFF_FFFF);
    write_cfg(REG_LOW_STEP, 32'h0);
    write_cfg(REG_TONE_SAMP, 32'h0);
    write_cfg(8'hFF, $urandom());   // unmapped index, ignored
    send_tick(1, 0, 0);
    random_ticks(60);
    settle();

    write_cfg(REG_GAIN, 32'h0);
    write_cfg(REG_HIGH_STEP, 32'h0);
    write_cfg(REG_LOW_STEP, 32'hFFFF_FFFF);
    write_cfg(REG_TONE_SAMP, 32'h000F_FFFF);
    send_tick(1, 0, 1);
    random_ticks(40);
    settle();

    write_cfg(REG_GAIN, 32'h0001_0000);
    write_cfg(REG_TONE_SAMP, 32'd1);
    send_tick(1, 0, 0);
    random_ticks(40);
    settle();

    // random settings, short tones so both tones get heard
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(REG_GAIN, $urandom_range(0, 131071));
      write_cfg(REG_HIGH_STEP, $urandom());
      write_cfg(REG_LOW_STEP, $urandom());
      write_cfg(REG_TONE_SAMP, $urandom_range(1, 40));
      write_cfg(8'($urandom_range(4, 254)), $urandom());
      no_idle = (ph == 2);
      send_tick(1, 0, 0);
      random_ticks(35);
      settle();
    end

    $display("Checked %0d samples across %0d register writes, done flagged on %0d.",
             sb.n_ok, n_cfg, sb.n_done);
    if (sb.n_err == 0 && sb.exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
